// ===== rtl/core/pedec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedec_pkg
// Shared types, constants and the hex digit helper for the percent decoder.
// ----------------------------------------------------------------------------
package pedec_pkg;

   localparam int CHAR_W      = 16;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;

   localparam logic [CHAR_W-1:0] PERCENT_CHAR = 16'h0025;

   typedef struct packed {
      logic escape_open;
      logic held_count;
   } state_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              has_char;
      logic              last;
      logic              error;
   } result_type;

   typedef result_type [MAX_RESULTS-1:0] results_type;

   // msb set when the character is a hex digit, low nibble is its value
   function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         r = {1'b1, 4'(c - 16'h0030)};
      end else if (c >= 16'h0041 && c <= 16'h0046) begin
         r = {1'b1, 4'(c - 16'h0041 + 16'd10)};
      end else if (c >= 16'h0061 && c <= 16'h0066) begin
         r = {1'b1, 4'(c - 16'h0061 + 16'd10)};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/pedec_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedec_decode
// Single-pass decode of one character into up to three results and the
// next escape state.
// ----------------------------------------------------------------------------
module pedec_decode import pedec_pkg::*; (
   input  logic                enable,
   input  logic [CHAR_W-1:0]   in_char,
   input  logic                in_last,
   input  state_type           state_q,
   input  logic [CHAR_W-1:0]   held_q,
   output state_type           state_d,
   output logic [CHAR_W-1:0]   held_d,
   output results_type         results,
   output logic [CNT_W-1:0]    res_cnt
);

   logic [4:0] hex_hi;
   logic [4:0] hex_lo;

   assign hex_hi = hex_digit(held_q);
   assign hex_lo = hex_digit(in_char);

   always_comb begin
      results = '0;
      res_cnt = '0;
      state_d = state_q;
      held_d  = held_q;
      if (!enable) begin
         results[0].out_char = in_char;
         results[0].has_char = 1'b1;
         results[0].last     = in_last;
         res_cnt             = 2'd1;
         state_d             = '0;
      end else begin
         if (!state_q.escape_open) begin
            if (in_char == PERCENT_CHAR) begin
               state_d.escape_open = 1'b1;
               state_d.held_count  = 1'b0;
            end else begin
               results[0].out_char = {8'h00, in_char[7:0]};
               results[0].has_char = 1'b1;
               res_cnt             = 2'd1;
            end
         end else if (!state_q.held_count) begin
            held_d             = in_char;
            state_d.held_count = 1'b1;
         end else begin
            state_d = '0;
            if (hex_hi[4] && hex_lo[4]) begin
               results[0].out_char = {8'h00, hex_hi[3:0], hex_lo[3:0]};
               results[0].has_char = 1'b1;
               res_cnt             = 2'd1;
            end else begin
               results[0].out_char = PERCENT_CHAR;
               results[0].has_char = 1'b1;
               if (held_q == PERCENT_CHAR) begin
                  // second percent reopens the escape with this char held
                  state_d.escape_open = 1'b1;
                  state_d.held_count  = 1'b1;
                  held_d              = in_char;
                  res_cnt             = 2'd1;
               end else begin
                  results[1].out_char = {8'h00, held_q[7:0]};
                  results[1].has_char = 1'b1;
                  if (in_char == PERCENT_CHAR) begin
                     state_d.escape_open = 1'b1;
                     res_cnt             = 2'd2;
                  end else begin
                     results[2].out_char = {8'h00, in_char[7:0]};
                     results[2].has_char = 1'b1;
                     res_cnt             = 2'd3;
                  end
               end
            end
         end
         if (in_last) begin
            // string ends inside an escape: bare error result
            if (state_d.escape_open) begin
               results[res_cnt].last  = 1'b1;
               results[res_cnt].error = 1'b1;
               res_cnt                = res_cnt + 2'd1;
            end else begin
               results[res_cnt - 2'd1].last = 1'b1;
            end
            state_d = '0;
         end
      end
   end

endmodule

// ===== rtl/core/pedec_burst.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedec_burst
// Result register holding one item's results, drained one per transfer.
// ----------------------------------------------------------------------------
module pedec_burst import pedec_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  results_type        load_results,
   input  logic [CNT_W-1:0]   load_cnt,
   output logic               free,
   output logic               out_valid,
   input  logic               out_stall,
   output result_type         out_result
);

   results_type      slots_ff, slots_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_xfer;

   assign out_valid  = (cnt_ff != '0);
   assign out_xfer   = out_valid && !out_stall;
   assign out_result = slots_ff[0];
   // room for a new item once the last held result leaves this cycle
   assign free = (cnt_ff == '0) || (cnt_ff == 2'd1 && out_xfer);

   always_comb begin
      slots_in = slots_ff;
      cnt_in   = cnt_ff;
      if (out_xfer) begin
         slots_in[0] = slots_ff[1];
         slots_in[1] = slots_ff[2];
         cnt_in      = cnt_ff - 2'd1;
      end
      if (load) begin
         slots_in = load_results;
         cnt_in   = load_cnt;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/percent_escape_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder_core
// Percent-escape decoder for a stream of 16-bit characters.
// Input is registered, decoded and the results held in the result register.
// Throughput: one character per cycle while the result register is free; an
// item with n results stalls the input while they drain one per transfer.
// Reset: synchronous active high, clears escape state, buffers and enable.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core import pedec_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_url_decode_enable,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CHAR_W-1:0]  req_in_char,
   input  logic               req_last_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_has_char,
   output logic               rsp_last,
   output logic               rsp_error
);

   logic              enable_ff;
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;
   state_type         state_ff, state_in;
   logic [CHAR_W-1:0] held_ff, held_in;
   results_type       dec_results;
   logic [CNT_W-1:0]  dec_cnt;
   logic              burst_free;
   logic              advance;
   logic              req_xfer;
   result_type        head;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && burst_free;
   assign req_stall = in_valid_ff && !burst_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   pedec_decode u_decode (
      .enable  (enable_ff),
      .in_char (in_char_ff),
      .in_last (in_last_ff),
      .state_q (state_ff),
      .held_q  (held_ff),
      .state_d (state_in),
      .held_d  (held_in),
      .results (dec_results),
      .res_cnt (dec_cnt)
   );

   pedec_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (advance && dec_cnt != '0),
      .load_results (dec_results),
      .load_cnt     (dec_cnt),
      .free         (burst_free),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_result   (head)
   );

   assign rsp_out_char = head.out_char;
   assign rsp_has_char = head.has_char;
   assign rsp_last     = head.last;
   assign rsp_error    = head.error;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff <= req_in_char;
         in_last_ff <= req_last_char;
      end
      if (advance) begin
         held_ff <= held_in;
      end
      if (reset) begin
         enable_ff   <= 1'b0;
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_url_decode_enable;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_error_is_bare_final : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_has_char && rsp_last)
      else $error("error result carries a character or is not final");

   a_bare_char_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_out_char == '0)
      else $error("bare result with nonzero character");

   a_reset_empty : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
